// ===== sv/bez_pkg.sv =====
// shared types and constants for the cubic bezier point evaluator
// no dependencies; imported by every module of the block
package bez_pkg;

  // default widths of a coordinate and of the fraction of t
  localparam int COORD_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 16;

  // three interpolation levels, each a multiply stage and an add stage
  localparam int NUM_LEVELS       = 3;
  localparam int STAGES_PER_LEVEL = 2;
  localparam int NUM_STAGES       = NUM_LEVELS * STAGES_PER_LEVEL;

  // control point register file
  localparam int NUM_REGS     = 8;
  localparam int CFG_IDX_BITS = 3;

  localparam logic [CFG_IDX_BITS-1:0] REG_START_X  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_START_Y  = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_GUIDE1_X = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_GUIDE1_Y = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_GUIDE2_X = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_GUIDE2_Y = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_END_X    = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] REG_END_Y    = 3'd7;

  // load strobes for the two register stages of one interpolation level
  typedef struct packed {
    logic mul_en;
    logic add_en;
  } bez_lerp_en_t;

endpackage

// ===== sv/bez_cfg.sv =====
// control point register file, written through the config channel
// depends on bez_pkg
module bez_cfg #(
  parameter int COORD_BITS = bez_pkg::COORD_BITS_DEF
) (
  input  logic                                                   clk_i,
  input  logic                                                   rst_ni,
  input  logic                                                   cfg_valid_i,
  output logic                                                   cfg_ready_o,
  input  logic [bez_pkg::CFG_IDX_BITS-1:0]                       cfg_index_i,
  input  logic [COORD_BITS-1:0]                                  cfg_data_i,
  output logic [bez_pkg::NUM_REGS-1:0][COORD_BITS-1:0]           regs_o
);
  import bez_pkg::*;

  logic [NUM_REGS-1:0][COORD_BITS-1:0] regs_q;

  // writes are always taken
  assign cfg_ready_o = 1'b1;

  // register write decode
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_START_X:  regs_q[REG_START_X]  <= cfg_data_i;
        REG_START_Y:  regs_q[REG_START_Y]  <= cfg_data_i;
        REG_GUIDE1_X: regs_q[REG_GUIDE1_X] <= cfg_data_i;
        REG_GUIDE1_Y: regs_q[REG_GUIDE1_Y] <= cfg_data_i;
        REG_GUIDE2_X: regs_q[REG_GUIDE2_X] <= cfg_data_i;
        REG_GUIDE2_Y: regs_q[REG_GUIDE2_Y] <= cfg_data_i;
        REG_END_X:    regs_q[REG_END_X]    <= cfg_data_i;
        REG_END_Y:    regs_q[REG_END_Y]    <= cfg_data_i;
        default:      regs_q <= regs_q;
      endcase
    end
  end

  assign regs_o = regs_q;

endmodule

// ===== sv/bez_lerp.sv =====
// one rounded linear interpolation a + round((b - a) * t), two register stages
// depends on bez_pkg
module bez_lerp #(
  parameter int COORD_BITS = bez_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = bez_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk_i,
  input  bez_pkg::bez_lerp_en_t        en_i,
  input  logic [COORD_BITS-1:0]        a_i,
  input  logic [COORD_BITS-1:0]        b_i,
  input  logic [FRAC_BITS:0]           t_i,
  output logic [COORD_BITS-1:0]        res_o
);
  import bez_pkg::*;

  // product of a coordinate difference and t, with room for the sign
  localparam int PW = COORD_BITS + FRAC_BITS + 2;
  localparam logic [PW-1:0] HALF =
    {{(PW - FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS - 1){1'b0}}};

  logic signed [COORD_BITS:0] diff;
  logic signed [PW-1:0]       prod_d, prod_q;
  logic signed [PW-1:0]       rnd, scaled;
  logic [COORD_BITS-1:0]      a_q;
  logic [COORD_BITS-1:0]      res_d, res_q;

  // stage 1: difference and multiply
  assign diff   = $signed({b_i[COORD_BITS-1], b_i}) - $signed({a_i[COORD_BITS-1], a_i});
  assign prod_d = PW'(diff) * $signed(PW'(t_i));

  always_ff @(posedge clk_i) begin
    if (en_i.mul_en) begin
      prod_q <= prod_d;
      a_q    <= a_i;
    end
  end

  // stage 2: round half up, floor scale, add base point
  assign rnd    = prod_q + $signed(HALF);
  assign scaled = rnd >>> FRAC_BITS;
  assign res_d  = a_q + scaled[COORD_BITS-1:0];

  always_ff @(posedge clk_i) begin
    if (en_i.add_en) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

// ===== sv/bez_ctrl.sv =====
// pipeline control: per-stage valid bits, load strobes and the t delay line
// depends on bez_pkg
module bez_ctrl #(
  parameter int FRAC_BITS = bez_pkg::FRAC_BITS_DEF
) (
  input  logic                                                   clk_i,
  input  logic                                                   rst_ni,
  input  logic                                                   in_valid_i,
  output logic                                                   in_ready_o,
  input  logic [FRAC_BITS:0]                                     param_t_i,
  output logic                                                   out_valid_o,
  input  logic                                                   out_ready_i,
  output bez_pkg::bez_lerp_en_t [bez_pkg::NUM_LEVELS-1:0]        lvl_en_o,
  output logic [bez_pkg::NUM_LEVELS-1:0][FRAC_BITS:0]            lvl_t_o
);
  import bez_pkg::*;

  localparam logic [FRAC_BITS:0] T_ONE = {1'b1, {FRAC_BITS{1'b0}}};
  // t is needed up to the input of the last level
  localparam int TL = NUM_STAGES - STAGES_PER_LEVEL;

  logic [NUM_STAGES-1:0] vld_q, vld_d, prev_vld, load;
  logic [NUM_STAGES:0]   adv;
  logic [FRAC_BITS:0]    t_sat;
  logic [TL-1:0][FRAC_BITS:0] t_q, t_prev;

  // a stage loads when it is empty or its contents move on
  always_comb begin
    adv[NUM_STAGES] = out_ready_i;
    for (int s = NUM_STAGES - 1; s >= 0; s--) begin
      adv[s] = ~vld_q[s] | adv[s + 1];
    end
  end

  assign load       = adv[NUM_STAGES-1:0];
  assign in_ready_o = adv[0];
  assign prev_vld   = {vld_q[NUM_STAGES-2:0], in_valid_i};
  assign vld_d      = (load & prev_vld) | (~load & vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign out_valid_o = vld_q[NUM_STAGES-1];

  // t beyond one saturates to one
  assign t_sat = param_t_i[FRAC_BITS] ? T_ONE : param_t_i;

  // t delay line, moving with the stages
  assign t_prev = {t_q[TL-2:0], t_sat};

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < TL; k++) begin
      if (load[k]) begin
        t_q[k] <= t_prev[k];
      end
    end
  end

  // strobes and t per level
  always_comb begin
    for (int l = 0; l < NUM_LEVELS; l++) begin
      lvl_en_o[l].mul_en = load[STAGES_PER_LEVEL * l];
      lvl_en_o[l].add_en = load[STAGES_PER_LEVEL * l + 1];
    end
  end

  assign lvl_t_o[0] = t_sat;
  for (genvar l = 1; l < NUM_LEVELS; l++) begin : g_lvl_t
    assign lvl_t_o[l] = t_q[STAGES_PER_LEVEL * l - 1];
  end

endmodule

// ===== sv/cubic_bezier_point_eval.sv =====
// cubic bezier point evaluator, top level: de casteljau in three lerp levels
// depends on bez_pkg, bez_cfg, bez_lerp, bez_ctrl
//
//   channel | direction | handshake               | word
//   --------+-----------+-------------------------+----------------------------
//   cfg     | in        | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//   in      | in        | in_valid_i/in_ready_o   | param_t_i
//   out     | out       | out_valid_o/out_ready_i | point_x_o, point_y_o
//
// a word is taken every cycle while in_ready_o is high; there are two register stages
// (multiply, then round and add) for each of the three interpolation levels.
// each stage loads when it is empty or drains, so bubbles close up under a stall
// and in_ready_o drops only when all six stages hold words and out is stalled.
// reset clears the valid bits and zeroes the control points.
// cfg_ready_o is always high.
module cubic_bezier_point_eval #(
  parameter int COORD_BITS = bez_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = bez_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [bez_pkg::CFG_IDX_BITS-1:0]     cfg_index_i,
  input  logic [COORD_BITS-1:0]                cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [FRAC_BITS:0]                   param_t_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [COORD_BITS-1:0]         point_x_o,
  output logic signed [COORD_BITS-1:0]         point_y_o
);
  import bez_pkg::*;

  logic [NUM_REGS-1:0][COORD_BITS-1:0]   regs;
  bez_lerp_en_t [NUM_LEVELS-1:0]         lvl_en;
  logic [NUM_LEVELS-1:0][FRAC_BITS:0]    lvl_t;

  // per axis: control points and the points of each level
  logic [1:0][3:0][COORD_BITS-1:0] ctl_pt;
  logic [1:0][2:0][COORD_BITS-1:0] lv1;
  logic [1:0][1:0][COORD_BITS-1:0] lv2;
  logic [1:0][COORD_BITS-1:0]      lv3;

  bez_cfg #(
    .COORD_BITS (COORD_BITS)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .regs_o      (regs)
  );

  bez_ctrl #(
    .FRAC_BITS (FRAC_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .param_t_i   (param_t_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .lvl_en_o    (lvl_en),
    .lvl_t_o     (lvl_t)
  );

  // control points, x axis then y axis
  assign ctl_pt[0][0] = regs[REG_START_X];
  assign ctl_pt[0][1] = regs[REG_GUIDE1_X];
  assign ctl_pt[0][2] = regs[REG_GUIDE2_X];
  assign ctl_pt[0][3] = regs[REG_END_X];
  assign ctl_pt[1][0] = regs[REG_START_Y];
  assign ctl_pt[1][1] = regs[REG_GUIDE1_Y];
  assign ctl_pt[1][2] = regs[REG_GUIDE2_Y];
  assign ctl_pt[1][3] = regs[REG_END_Y];

  for (genvar ax = 0; ax < 2; ax++) begin : g_axis
    // first level: three segments of the control polygon
    for (genvar i = 0; i < 3; i++) begin : g_lv1
      bez_lerp #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
      ) u_lerp (
        .clk_i (clk_i),
        .en_i  (lvl_en[0]),
        .a_i   (ctl_pt[ax][i]),
        .b_i   (ctl_pt[ax][i+1]),
        .t_i   (lvl_t[0]),
        .res_o (lv1[ax][i])
      );
    end

    // second level
    for (genvar i = 0; i < 2; i++) begin : g_lv2
      bez_lerp #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
      ) u_lerp (
        .clk_i (clk_i),
        .en_i  (lvl_en[1]),
        .a_i   (lv1[ax][i]),
        .b_i   (lv1[ax][i+1]),
        .t_i   (lvl_t[1]),
        .res_o (lv2[ax][i])
      );
    end

    // last level gives the curve point
    bez_lerp #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS)
    ) u_lerp3 (
      .clk_i (clk_i),
      .en_i  (lvl_en[2]),
      .a_i   (lv2[ax][0]),
      .b_i   (lv2[ax][1]),
      .t_i   (lvl_t[2]),
      .res_o (lv3[ax])
    );
  end

  assign point_x_o = $signed(lv3[0]);
  assign point_y_o = $signed(lv3[1]);

endmodule

// ===== sv/bez_chk.sv =====
// port-level checks for the cubic bezier point evaluator, bound to the top
// depends on bez_pkg and cubic_bezier_point_eval
module bez_chk #(
  parameter int COORD_BITS = bez_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = bez_pkg::FRAC_BITS_DEF
) (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               cfg_valid_i,
  input logic                               cfg_ready_o,
  input logic [bez_pkg::CFG_IDX_BITS-1:0]   cfg_index_i,
  input logic [COORD_BITS-1:0]              cfg_data_i,
  input logic                               in_valid_i,
  input logic                               in_ready_o,
  input logic [FRAC_BITS:0]                 param_t_i,
  input logic                               out_valid_o,
  input logic                               out_ready_i,
  input logic signed [COORD_BITS-1:0]       point_x_o,
  input logic signed [COORD_BITS-1:0]       point_y_o
);
  import bez_pkg::*;

  // a stalled output word holds its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(point_x_o) && $stable(point_y_o))
    else $error("output word changed while stalled");

  // input is blocked only while the pipeline is full and out is stalled
  a_in_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input blocked without an output stall");

  // with out never stalled, an accepted word reaches the output
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) ##1 out_ready_i ##1 out_ready_i ##1 out_ready_i
      ##1 out_ready_i ##1 out_ready_i |=> out_valid_o)
    else $error("word not delivered after six free cycles");

  // a waiting input word keeps its valid and payload
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(param_t_i))
    else $error("input word changed while waiting");

  // a waiting config word keeps its valid, index and data
  a_cfg_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && !cfg_ready_o |=>
      cfg_valid_i && $stable(cfg_index_i) && $stable(cfg_data_i))
    else $error("config word changed while waiting");

endmodule

bind cubic_bezier_point_eval bez_chk #(
  .COORD_BITS (COORD_BITS),
  .FRAC_BITS  (FRAC_BITS)
) u_bez_chk (.*);

// ===== test/tb_cubic_bezier_point_eval.sv =====
// testbench for cubic_bezier_point_eval: control point writes, parameter words, point checks
// depends on bez_pkg and the cubic_bezier_point_eval rtl; needs nothing else
`timescale 1ns / 100ps

module tb_cubic_bezier_point_eval;
  import bez_pkg::*;

  localparam int COORD_BITS  = 16;
  localparam int FRAC_BITS   = 16;
  localparam longint T_ONE   = longint'(1) << FRAC_BITS;
  localparam longint T_HALF  = T_ONE >> 1;
  localparam int LATENCY     = NUM_STAGES;
  localparam int HOLD_CYCLES = 160;
  localparam int CYCLE_LIMIT = 400000;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [FRAC_BITS:0] param_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } curve_pt_t;

  // receiver ready patterns
  typedef enum int {RX_ALWAYS, RX_HALF, RX_MOSTLY, RX_SPARSE} rx_mode_e;

  // kinds of random control point sets
  typedef enum int {CK_FULL, CK_NEAR, CK_EDGE, CK_FLAT} curve_kind_e;

  logic clk_i;
  logic rst_ni;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [CFG_IDX_BITS-1:0] cfg_index_i;
  logic [COORD_BITS-1:0] cfg_data_i;
  logic in_valid_i;
  logic in_ready_o;
  param_t param_t_i;
  logic out_valid_o;
  logic out_ready_i;
  coord_t point_x_o;
  coord_t point_y_o;

  cubic_bezier_point_eval #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .param_t_i  (param_t_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .point_x_o  (point_x_o),
    .point_y_o  (point_y_o)
  );

  // shadow copy of the control points and the points still owed by the block
  coord_t ctrl_pts [NUM_REGS];
  curve_pt_t pending_points[$];

  int error_count;
  int points_checked;
  int params_sent;
  int cfg_writes;
  int curve_count;
  int stall_cycles;
  int cycle_count;
  int burst_left;
  int tx_gap_max;
  int hold_requests;

  // one interpolation step: a + floor(((b-a)*t + half) / one)
  function automatic longint lerp_q(longint a, longint b, longint t);
    return a + (((b - a) * t + T_HALF) >>> FRAC_BITS);
  endfunction

  // three levels of de casteljau on one axis
  function automatic coord_t casteljau_axis(longint p0, longint p1, longint p2, longint p3,
                                            longint t);
    longint ab, bc, cd, abc, bcd, r;
    ab  = lerp_q(p0, p1, t);
    bc  = lerp_q(p1, p2, t);
    cd  = lerp_q(p2, p3, t);
    abc = lerp_q(ab, bc, t);
    bcd = lerp_q(bc, cd, t);
    r   = lerp_q(abc, bcd, t);
    return r[COORD_BITS-1:0];
  endfunction

  // curve point for one parameter word, t above one clamps to the end point
  function automatic curve_pt_t eval_curve_point(param_t t_raw);
    longint t;
    curve_pt_t pt;
    t = (longint'(t_raw) > T_ONE) ? T_ONE : longint'(t_raw);
    pt.x = casteljau_axis(ctrl_pts[REG_START_X], ctrl_pts[REG_GUIDE1_X],
                          ctrl_pts[REG_GUIDE2_X], ctrl_pts[REG_END_X], t);
    pt.y = casteljau_axis(ctrl_pts[REG_START_Y], ctrl_pts[REG_GUIDE1_Y],
                          ctrl_pts[REG_GUIDE2_Y], ctrl_pts[REG_END_Y], t);
    return pt;
  endfunction

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // cycle limit
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t timeout after %0d cycles, %0d points outstanding", $time, cycle_count,
               pending_points.size());
      $display("cubic_bezier_point_eval test failed");
      $finish;
    end
  end

  // watch all three channels at the rising edge
  always @(posedge clk_i) begin
    curve_pt_t exp_pt;
    if (rst_ni) begin
      // check the result word against the oldest expectation
      if (out_valid_o && out_ready_i) begin
        if (pending_points.size() == 0) begin
          $display("%0t unexpected point x=%0d y=%0d", $time, point_x_o, point_y_o);
          error_count++;
        end else begin
          exp_pt = pending_points.pop_front();
          points_checked++;
          if (point_x_o !== exp_pt.x) begin
            $display("%0t point_x mismatch: expected %0d actual %0d", $time, exp_pt.x,
                     point_x_o);
            error_count++;
          end
          if (point_y_o !== exp_pt.y) begin
            $display("%0t point_y mismatch: expected %0d actual %0d", $time, exp_pt.y,
                     point_y_o);
            error_count++;
          end
        end
      end
      // predict the point for an accepted parameter word
      if (in_valid_i && in_ready_o) begin
        pending_points.push_back(eval_curve_point(param_t_i));
        params_sent++;
      end
      if (in_valid_i && !in_ready_o) stall_cycles++;
      // mirror control point writes
      if (cfg_valid_i && cfg_ready_o) begin
        ctrl_pts[cfg_index_i] = cfg_data_i;
        cfg_writes++;
      end
    end
  end

  // receiver: ready pattern changes per segment, long hold-off on request
  initial begin
    rx_mode_e rx_mode;
    int seg_left;
    int hold_left;
    int hold_served;
    out_ready_i = 1'b0;
    rx_mode     = RX_ALWAYS;
    seg_left    = 0;
    hold_left   = 0;
    hold_served = 0;
    forever begin
      @(negedge clk_i);
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          rx_mode  = rx_mode_e'($urandom_range(RX_ALWAYS, RX_SPARSE));
          seg_left = $urandom_range(5, 60);
        end
        seg_left--;
        case (rx_mode)
          RX_ALWAYS: out_ready_i <= 1'b1;
          RX_HALF:   out_ready_i <= 1'($urandom_range(0, 1));
          RX_MOSTLY: out_ready_i <= ($urandom_range(0, 7) != 0);
          default:   out_ready_i <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // send one parameter word, opening a new burst after a random gap when due
  task automatic send_param(input param_t t);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (tx_gap_max == 0) ? 0 : $urandom_range(0, tx_gap_max);
      if (tx_gap_max != 0 && $urandom_range(0, 9) == 0) gap += $urandom_range(8, 20);
      if (gap > 0) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    param_t_i  <= t;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // drop valid and wait for every owed point, then let the pipe drain
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (pending_points.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 2) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input coord_t data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // load all four control points; caller makes sure the block is idle
  task automatic set_curve(input coord_t sx, input coord_t sy, input coord_t g1x,
                           input coord_t g1y, input coord_t g2x, input coord_t g2y,
                           input coord_t ex, input coord_t ey);
    write_reg(REG_START_X, sx);
    write_reg(REG_START_Y, sy);
    write_reg(REG_GUIDE1_X, g1x);
    write_reg(REG_GUIDE1_Y, g1y);
    write_reg(REG_GUIDE2_X, g2x);
    write_reg(REG_GUIDE2_Y, g2y);
    write_reg(REG_END_X, ex);
    write_reg(REG_END_Y, ey);
    curve_count++;
  endtask

  function automatic coord_t rand_coord(curve_kind_e kind);
    case (kind)
      CK_NEAR: return coord_t'(int'($urandom_range(0, 200)) - 100);
      CK_EDGE: begin
        case ($urandom_range(0, 4))
          0:       return coord_t'(-32768);
          1:       return coord_t'(32767);
          2:       return coord_t'(0);
          3:       return coord_t'(-1);
          default: return coord_t'(1);
        endcase
      end
      default: return coord_t'($urandom_range(0, 65535));
    endcase
  endfunction

  // mostly in range, some edges, some beyond one, some fully random
  function automatic param_t rand_param();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 7) return param_t'($urandom_range(0, 65536));
    if (pick == 7) begin
      case ($urandom_range(0, 5))
        0:       return param_t'(0);
        1:       return param_t'(1);
        2:       return param_t'(32767);
        3:       return param_t'(32768);
        4:       return param_t'(65535);
        default: return param_t'(65536);
      endcase
    end
    if (pick == 8) return param_t'($urandom_range(65537, 131071));
    return param_t'($urandom);
  endfunction

  // points after reset are all at the origin
  task automatic test_reset_points();
    send_param(param_t'(0));
    send_param(param_t'(32768));
    send_param(param_t'(65536));
    wait_idle();
  endtask

  // extreme coordinates, edge parameters, t beyond one and rounding of halves
  task automatic test_extreme_points();
    set_curve(coord_t'(-32768), coord_t'(-32768), coord_t'(32767), coord_t'(32767),
              coord_t'(-32768), coord_t'(32767), coord_t'(32767), coord_t'(-32768));
    send_param(param_t'(0));
    send_param(param_t'(1));
    send_param(param_t'(32768));
    send_param(param_t'(65535));
    send_param(param_t'(65536));
    send_param(param_t'(65537));
    send_param(param_t'(131071));
    wait_idle();
    set_curve(coord_t'(32767), coord_t'(32767), coord_t'(32767), coord_t'(32767),
              coord_t'(32767), coord_t'(32767), coord_t'(32767), coord_t'(32767));
    send_param(param_t'(21845));
    send_param(param_t'(131071));
    wait_idle();
    set_curve(coord_t'(-32768), coord_t'(-32768), coord_t'(-32768), coord_t'(-32768),
              coord_t'(-32768), coord_t'(-32768), coord_t'(-32768), coord_t'(-32768));
    send_param(param_t'(43690));
    send_param(param_t'(65536));
    wait_idle();
    // halves round up, on both signs of the difference
    set_curve(coord_t'(0), coord_t'(0), coord_t'(1), coord_t'(-1),
              coord_t'(1), coord_t'(-1), coord_t'(0), coord_t'(0));
    send_param(param_t'(32768));
    send_param(param_t'(16384));
    send_param(param_t'(49152));
    send_param(param_t'(98304));
    wait_idle();
  endtask

  // random control points and parameters over several settings
  task automatic test_random_curves();
    curve_kind_e kind;
    coord_t c;
    for (int phase = 0; phase < 8; phase++) begin
      kind = curve_kind_e'(phase % 4);
      if (kind == CK_FLAT) begin
        c = rand_coord(CK_FULL);
        set_curve(c, c, c, c, c, c, c, c);
      end else begin
        set_curve(rand_coord(kind), rand_coord(kind), rand_coord(kind), rand_coord(kind),
                  rand_coord(kind), rand_coord(kind), rand_coord(kind), rand_coord(kind));
      end
      case (phase % 3)
        0:       tx_gap_max = 0;
        1:       tx_gap_max = 3;
        default: tx_gap_max = 12;
      endcase
      repeat (52) send_param(rand_param());
      wait_idle();
    end
  endtask

  // receiver holds off while the sender keeps offering, so the input stalls
  task automatic test_output_holdoff();
    set_curve(rand_coord(CK_FULL), rand_coord(CK_FULL), rand_coord(CK_FULL),
              rand_coord(CK_FULL), rand_coord(CK_FULL), rand_coord(CK_FULL),
              rand_coord(CK_FULL), rand_coord(CK_FULL));
    tx_gap_max = 0;
    hold_requests++;
    repeat (40) send_param(rand_param());
    wait_idle();
  endtask

  initial begin
    error_count    = 0;
    points_checked = 0;
    params_sent    = 0;
    cfg_writes     = 0;
    curve_count    = 0;
    stall_cycles   = 0;
    burst_left     = 0;
    tx_gap_max     = 3;
    hold_requests  = 0;
    for (int i = 0; i < NUM_REGS; i++) ctrl_pts[i] = '0;
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    param_t_i   = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_points();
    test_extreme_points();
    test_random_curves();
    test_output_holdoff();

    $display("checked %0d curve points over %0d control point sets (%0d register writes)",
             points_checked, curve_count, cfg_writes);
    $display("input held back by the block for %0d cycles, %0d errors", stall_cycles,
             error_count);
    if (error_count == 0 && pending_points.size() == 0) begin
      $display("cubic_bezier_point_eval test passed");
    end else begin
      $display("cubic_bezier_point_eval test failed");
    end
    $finish;
  end

endmodule
